[rtl/online_tree_lca_engine_macros.svh]
// Assertion macros shared by the RTL of the online tree LCA engine.
// No dependencies; expects signals named clock and reset in the using module.
`ifndef ONLINE_TREE_LCA_ENGINE_MACROS_SVH
`define ONLINE_TREE_LCA_ENGINE_MACROS_SVH

// same-cycle implication
`define OLCA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OLCA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/olca_pkg.sv]
// Package for the online tree LCA engine: codes, FSM state type, entry type.
// No dependencies.
package olca_pkg;

   localparam int VERTEX_W = 10;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                valid;
      logic [VERTEX_W-1:0] vertex;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_ADD_LVL,
      ST_Q_READ,
      ST_Q_CMP,
      ST_Q_PAR,
      ST_FIN
   } state_type;

endpackage

[rtl/olca_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module olca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   output logic [WIDTH-1:0]         rdata0,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata0 <= mem_ff[raddr0];
      rdata1 <= mem_ff[raddr1];
   end

endmodule

[rtl/online_tree_lca_engine.sv]
// Top level of the online tree LCA engine (binary lifting over RAM tables).
// Depends on olca_pkg, olca_ram and online_tree_lca_engine_macros.svh.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_op, req_vertex_a, req_vertex_b
//  rsp     | out       | rsp_valid / rsp_stall | rsp_ancestor, rsp_rejected
//
// Add: fetch, check, one level-table write per cycle; a rejected add writes nothing.
// Query: fetch, check, then per level walked a read, a compare and, if needed, a
// parent step; the walk is bound by the level-table read followed by the dependent
// parent-table read. After reset a clearing pass empties the presence table.
// One transaction at a time; a new one is taken while a result waits on rsp_stall.
`include "online_tree_lca_engine_macros.svh"

module online_tree_lca_engine #(
   parameter int NUM_VERTICES = 1024,
   parameter int LEVELS       = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [olca_pkg::VERTEX_W-1:0] req_vertex_a,
   input  logic [olca_pkg::VERTEX_W-1:0] req_vertex_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [olca_pkg::VERTEX_W-1:0] rsp_ancestor,
   output logic                         rsp_rejected
);

   localparam int VW  = olca_pkg::VERTEX_W;
   localparam int AW  = $clog2(NUM_VERTICES);
   localparam int LAD = NUM_VERTICES * LEVELS;
   localparam int LAW = $clog2(LAD);
   localparam int LW  = $clog2(LEVELS);
   localparam int EW  = $bits(olca_pkg::entry_type);

   olca_pkg::state_type state_ff, state_in;

   logic            op_ff, op_in;
   logic [VW-1:0]   a_ff, a_in, b_ff, b_in, ans_ff, ans_in;
   logic            rej_ff, rej_in, done_ff, done_in;
   logic            pa_ff, pa_in, pb_ff, pb_in;
   logic [LW-1:0]   lvl_ff, lvl_in;
   logic [LAW-1:0]  base_a_ff, base_a_in, base_b_ff, base_b_in;
   logic [LEVELS-1:0] dpar_ff, dpar_in, dchild_ff, dchild_in;
   olca_pkg::entry_type ea_ff, ea_in, eb_ff, eb_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]   rsp_ancestor_ff, rsp_ancestor_in;
   logic            rsp_rejected_ff, rsp_rejected_in;

   // RAM ports
   logic            prs_we, prs_wdata, prs_rd0, prs_rd1;
   logic [AW-1:0]   prs_waddr;
   logic            par_we;
   logic [AW-1:0]   par_waddr, par_raddr0, par_raddr1;
   logic [VW-1:0]   par_wdata, par_rd0, par_rd1;
   logic            dep_we;
   logic [AW-1:0]   dep_waddr;
   logic [LEVELS-1:0] dep_wdata, dep_rd0;
   logic            la_we;
   logic [LAW-1:0]  la_waddr, la_raddr0, la_raddr1;
   olca_pkg::entry_type la_wdata, la_rd0, la_rd1;

   // datapath
   logic            a_ok, b_ok, pres_a, pres_b;
   logic [LEVELS-1:0] dpar, dchild, lvl_mask, d_lvl;
   olca_pkg::entry_type root_ent, par_ent, ea, eb, add_val;
   logic            add_set_done;
   logic [LW-1:0]   lvl_dec;
   logic [VW-1:0]   a_new, b_new;

   olca_ram #(.WIDTH(1), .DEPTH(NUM_VERTICES)) u_present (
      .clock(clock), .we(prs_we), .waddr(prs_waddr), .wdata(prs_wdata),
      .raddr0(AW'(a_ff)), .rdata0(prs_rd0), .raddr1(AW'(b_ff)), .rdata1(prs_rd1)
   );

   olca_ram #(.WIDTH(VW), .DEPTH(NUM_VERTICES)) u_parent (
      .clock(clock), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
      .raddr0(par_raddr0), .rdata0(par_rd0), .raddr1(par_raddr1), .rdata1(par_rd1)
   );

   olca_ram #(.WIDTH(LEVELS), .DEPTH(NUM_VERTICES)) u_depth (
      .clock(clock), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
      .raddr0(AW'(a_ff)), .rdata0(dep_rd0), .raddr1(AW'(a_ff)), .rdata1()
   );

   olca_ram #(.WIDTH(EW), .DEPTH(LAD)) u_level (
      .clock(clock), .we(la_we), .waddr(la_waddr), .wdata(la_wdata),
      .raddr0(la_raddr0), .rdata0(la_rd0), .raddr1(la_raddr1), .rdata1(la_rd1)
   );

   always_comb begin
      a_ok     = 32'(a_ff) < NUM_VERTICES;
      b_ok     = 32'(b_ff) < NUM_VERTICES;
      pres_a   = a_ok && ((a_ff == '0) || prs_rd0);
      pres_b   = b_ok && ((b_ff == '0) || prs_rd1);
      dpar     = (a_ff == '0) ? LEVELS'(1) : dep_rd0;
      dchild   = dpar + 1'b1;
      lvl_dec  = lvl_ff - 1'b1;
      lvl_mask = {LEVELS{1'b1}} << lvl_ff;
      d_lvl    = dchild_ff & lvl_mask;

      root_ent        = '0;
      root_ent.valid  = (lvl_ff == '0);
      par_ent         = (a_ff == '0) ? root_ent : la_rd0;
      ea              = pa_ff ? ((a_ff == '0) ? root_ent : la_rd0) : '0;
      eb              = pb_ff ? ((b_ff == '0) ? root_ent : la_rd1) : '0;

      add_val      = '0;
      add_set_done = 1'b0;
      if (!done_ff && dchild_ff[lvl_ff]) begin
         if (dpar_ff >= d_lvl) begin
            add_val = par_ent;
         end else begin
            add_val.valid  = 1'b1;
            add_val.vertex = b_ff;
            add_set_done   = 1'b1;
         end
      end

      a_new = ea_ff.valid ? ((ea_ff.vertex == '0) ? '0 : par_rd0) : a_ff;
      b_new = eb_ff.valid ? ((eb_ff.vertex == '0) ? '0 : par_rd1) : b_ff;
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      ans_in          = ans_ff;
      rej_in          = rej_ff;
      done_in         = done_ff;
      pa_in           = pa_ff;
      pb_in           = pb_ff;
      lvl_in          = lvl_ff;
      base_a_in       = base_a_ff;
      base_b_in       = base_b_ff;
      dpar_in         = dpar_ff;
      dchild_in       = dchild_ff;
      ea_in           = ea_ff;
      eb_in           = eb_ff;
      clr_in          = clr_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_ancestor_in = rsp_ancestor_ff;
      rsp_rejected_in = rsp_rejected_ff;
      req_stall       = 1'b1;

      prs_we     = 1'b0;
      prs_waddr  = AW'(b_ff);
      prs_wdata  = 1'b1;
      par_we     = 1'b0;
      par_waddr  = AW'(b_ff);
      par_wdata  = a_ff;
      par_raddr0 = AW'(ea.vertex);
      par_raddr1 = AW'(eb.vertex);
      dep_we     = 1'b0;
      dep_waddr  = AW'(b_ff);
      dep_wdata  = dchild;
      la_we      = 1'b0;
      la_waddr   = base_b_ff + LAW'(lvl_ff);
      la_wdata   = add_val;
      la_raddr0  = base_a_ff + LAW'(lvl_ff);
      la_raddr1  = base_b_ff + LAW'(lvl_ff);

      case (state_ff)
         olca_pkg::ST_CLEAR: begin
            prs_we    = 1'b1;
            prs_waddr = clr_ff;
            prs_wdata = 1'b0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(NUM_VERTICES - 1)) begin
               state_in = olca_pkg::ST_IDLE;
            end
         end
         olca_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in    = req_op;
               a_in     = req_vertex_a;
               b_in     = req_vertex_b;
               ans_in   = '0;
               rej_in   = 1'b0;
               done_in  = 1'b0;
               lvl_in   = LW'(LEVELS - 1);
               state_in = olca_pkg::ST_FETCH;
            end
         end
         olca_pkg::ST_FETCH: begin
            base_a_in = LAW'(32'(a_ff) * LEVELS);
            base_b_in = LAW'(32'(b_ff) * LEVELS);
            state_in  = olca_pkg::ST_CHECK;
         end
         olca_pkg::ST_CHECK: begin
            if (op_ff == olca_pkg::OP_ADD) begin
               if ((b_ff <= a_ff) || !b_ok || !pres_a || pres_b || (dpar == '1)) begin
                  rej_in   = 1'b1;
                  state_in = olca_pkg::ST_FIN;
               end else begin
                  prs_we    = 1'b1;
                  par_we    = 1'b1;
                  dep_we    = 1'b1;
                  dpar_in   = dpar;
                  dchild_in = dchild;
                  state_in  = olca_pkg::ST_ADD_LVL;
               end
            end else begin
               pa_in    = pres_a;
               pb_in    = pres_b;
               state_in = olca_pkg::ST_Q_READ;
            end
         end
         olca_pkg::ST_ADD_LVL: begin
            la_we     = 1'b1;
            la_raddr0 = base_a_ff + LAW'(lvl_dec);
            if (add_set_done) begin
               done_in = 1'b1;
            end
            if (lvl_ff == '0) begin
               state_in = olca_pkg::ST_FIN;
            end else begin
               lvl_in = lvl_dec;
            end
         end
         olca_pkg::ST_Q_READ: begin
            if (a_ff == b_ff) begin
               state_in = olca_pkg::ST_FIN;
            end else begin
               state_in = olca_pkg::ST_Q_CMP;
            end
         end
         olca_pkg::ST_Q_CMP: begin
            if (ea != eb) begin
               ea_in    = ea;
               eb_in    = eb;
               state_in = olca_pkg::ST_Q_PAR;
            end else begin
               if (eb.valid) begin
                  ans_in = eb.vertex;
               end
               if (lvl_ff == '0) begin
                  state_in = olca_pkg::ST_FIN;
               end else begin
                  lvl_in   = lvl_dec;
                  state_in = olca_pkg::ST_Q_READ;
               end
            end
         end
         olca_pkg::ST_Q_PAR: begin
            a_in      = a_new;
            b_in      = b_new;
            pa_in     = pa_ff || ea_ff.valid;
            pb_in     = pb_ff || eb_ff.valid;
            base_a_in = LAW'(32'(a_new) * LEVELS);
            base_b_in = LAW'(32'(b_new) * LEVELS);
            if (lvl_ff == '0) begin
               state_in = olca_pkg::ST_FIN;
            end else begin
               lvl_in   = lvl_dec;
               state_in = olca_pkg::ST_Q_READ;
            end
         end
         olca_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (op_ff == olca_pkg::OP_ADD) begin
                  rsp_ancestor_in = '0;
                  rsp_rejected_in = rej_ff;
               end else begin
                  rsp_ancestor_in = (a_ff == b_ff) ? b_ff : ans_ff;
                  rsp_rejected_in = 1'b0;
               end
               state_in = olca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = olca_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olca_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      a_ff            <= a_in;
      b_ff            <= b_in;
      ans_ff          <= ans_in;
      rej_ff          <= rej_in;
      done_ff         <= done_in;
      pa_ff           <= pa_in;
      pb_ff           <= pb_in;
      lvl_ff          <= lvl_in;
      base_a_ff       <= base_a_in;
      base_b_ff       <= base_b_in;
      dpar_ff         <= dpar_in;
      dchild_ff       <= dchild_in;
      ea_ff           <= ea_in;
      eb_ff           <= eb_in;
      rsp_ancestor_ff <= rsp_ancestor_in;
      rsp_rejected_ff <= rsp_rejected_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_ancestor_ff;
   assign rsp_rejected = rsp_rejected_ff;

   `OLCA_ASSERT_NEXT(a_accept_fetch, req_valid && !req_stall, state_ff == olca_pkg::ST_FETCH, "accepted transaction did not start fetch")
   `OLCA_ASSERT_IMPL(a_rsp_from_fin, $rose(rsp_valid_ff), $past(state_ff) == olca_pkg::ST_FIN, "response raised outside finish state")
   `OLCA_ASSERT_IMPL(a_add_level_range, state_ff == olca_pkg::ST_ADD_LVL, 32'(lvl_ff) < LEVELS, "add level counter out of range")
   `OLCA_ASSERT_NEXT(a_walk_present, (state_ff == olca_pkg::ST_Q_PAR) && ea_ff.valid, pa_ff, "query vertex moved to an absent vertex")

endmodule

[tb/sv/online_tree_lca_engine_checker.sv]
// Checker for online_tree_lca_engine: watches both channels, keeps its own lifting tables,
// predicts each result and compares it with the response. Depends on olca_pkg.
`timescale 1ns / 1ps

module online_tree_lca_engine_checker
   import olca_pkg::*;
#(
   parameter int NUM_VERTICES = 1024,
   parameter int LEVELS       = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_op,
   input  logic [VERTEX_W-1:0] req_vertex_a,
   input  logic [VERTEX_W-1:0] req_vertex_b,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [VERTEX_W-1:0] rsp_ancestor,
   input  logic                rsp_rejected,
   output int                  failures,
   output int                  outstanding
);

   localparam logic [LEVELS:0] MAX_DEPTH = (1 << LEVELS) - 1;

   typedef struct packed {
      logic [VERTEX_W-1:0] ancestor;
      logic                rejected;
   } answer_type;

   logic [VERTEX_W-1:0] parent_of [NUM_VERTICES];
   logic [LEVELS-1:0]   depth_of  [NUM_VERTICES];
   entry_type           lift      [NUM_VERTICES][LEVELS];
   bit                  on_tree   [NUM_VERTICES];

   answer_type pending_answers[$];
   int         mismatch_tally = 0;

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   function automatic void plant_root();
      for (int v = 0; v < NUM_VERTICES; v++) begin
         parent_of[v] = '0;
         depth_of[v]  = '0;
         on_tree[v]   = 1'b0;
         for (int i = 0; i < LEVELS; i++)
            lift[v][i] = '0;
      end
      depth_of[0]      = 1;
      on_tree[0]       = 1'b1;
      lift[0][0].valid = 1'b1;
   endfunction

   // returns 1 when the leaf was attached
   function automatic logic add_leaf(input logic [VERTEX_W-1:0] par,
                                     input logic [VERTEX_W-1:0] child);
      logic [LEVELS:0] new_depth;
      logic [LEVELS:0] floor_depth;
      logic            closed;
      entry_type       e;
      int              i;
      if (child <= par || !on_tree[par] || on_tree[child])
         return 1'b0;
      new_depth = depth_of[par] + 1'b1;
      if (new_depth > MAX_DEPTH)
         return 1'b0;
      parent_of[child] = par;
      depth_of[child]  = new_depth[LEVELS-1:0];
      on_tree[child]   = 1'b1;
      closed = 1'b0;
      for (i = LEVELS - 1; i >= 0; i--) begin
         e = '0;
         if (!closed && new_depth[i]) begin
            floor_depth = new_depth & ~(({{LEVELS{1'b0}}, 1'b1} << i) - 1'b1);
            if ({1'b0, depth_of[par]} >= floor_depth) begin
               e = lift[par][i];
            end else begin
               e.valid  = 1'b1;
               e.vertex = child;
               closed   = 1'b1;
            end
         end
         lift[child][i] = e;
      end
      return 1'b1;
   endfunction

   function automatic logic [VERTEX_W-1:0] lowest_common_ancestor(
         input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b);
      logic [VERTEX_W-1:0] found;
      entry_type           ea;
      entry_type           eb;
      int                  i;
      found = '0;
      for (i = LEVELS - 1; i >= 0 && a != b; i--) begin
         ea = lift[a][i];
         eb = lift[b][i];
         if (ea != eb) begin
            if (eb.valid) b = parent_of[eb.vertex];
            if (ea.valid) a = parent_of[ea.vertex];
         end else if (eb.valid) begin
            found = eb.vertex;
         end
      end
      return (a == b) ? b : found;
   endfunction

   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         plant_root();
         pending_answers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               mismatch_tally++;
               $display("%0t: unexpected result, ancestor %0d rejected %0d",
                        $time, rsp_ancestor, rsp_rejected);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_ancestor !== want.ancestor) begin
                  mismatch_tally++;
                  $display("%0t: ancestor mismatch, expected %0d actual %0d",
                           $time, want.ancestor, rsp_ancestor);
               end
               if (rsp_rejected !== want.rejected) begin
                  mismatch_tally++;
                  $display("%0t: rejected mismatch, expected %0d actual %0d",
                           $time, want.rejected, rsp_rejected);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_op == OP_ADD) begin
               want.ancestor = '0;
               want.rejected = !add_leaf(req_vertex_a, req_vertex_b);
            end else begin
               want.ancestor = lowest_common_ancestor(req_vertex_a, req_vertex_b);
               want.rejected = 1'b0;
            end
            pending_answers.push_back(want);
         end
      end
      outstanding <= pending_answers.size();
      failures    <= mismatch_tally;
   end

endmodule

[tb/sv/tb_online_tree_lca_engine.sv]
// Testbench top for online_tree_lca_engine: clock, reset, directed and random
// transactions with idle and stall phases. Depends on olca_pkg and the checker module.
`timescale 1ns / 1ps

module tb_online_tree_lca_engine;
   import olca_pkg::*;

   localparam int NUM_VERTICES    = 1024;
   localparam int LEVELS          = 20;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_ITEMS     = 80;

   logic                clock;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_stall;
   logic                req_op       = OP_QUERY;
   logic [VERTEX_W-1:0] req_vertex_a = '0;
   logic [VERTEX_W-1:0] req_vertex_b = '0;
   logic                rsp_valid;
   logic                rsp_stall    = 1'b0;
   logic [VERTEX_W-1:0] rsp_ancestor;
   logic                rsp_rejected;
   int                  failures;
   int                  outstanding;

   int unsigned send_idle_pct     = 0;
   int unsigned stall_pct         = 0;
   int unsigned hold_off_requests = 0;
   int unsigned cycle_count       = 0;

   // stimulus-side view of the tree, used only to shape the transactions
   bit                  on_tree [NUM_VERTICES];
   logic [VERTEX_W-1:0] members[$];
   logic [VERTEX_W-1:0] newest = '0;
   int unsigned         next_child = 5;

   online_tree_lca_engine #(
      .NUM_VERTICES(NUM_VERTICES),
      .LEVELS      (LEVELS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_vertex_a(req_vertex_a),
      .req_vertex_b(req_vertex_b),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_ancestor(rsp_ancestor),
      .rsp_rejected(rsp_rejected)
   );

   online_tree_lca_engine_checker #(
      .NUM_VERTICES(NUM_VERTICES),
      .LEVELS      (LEVELS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_vertex_a(req_vertex_a),
      .req_vertex_b(req_vertex_b),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_ancestor(rsp_ancestor),
      .rsp_rejected(rsp_rejected),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : receiver
      int unsigned served;
      served = 0;
      forever begin
         @(posedge clock);
         if (served != hold_off_requests) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
            served++;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic issue_transaction(input logic op, input logic [VERTEX_W-1:0] a,
                                    input logic [VERTEX_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_vertex_a <= a;
      req_vertex_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic grow_tree(input logic [VERTEX_W-1:0] par, input logic [VERTEX_W-1:0] child);
      if (child > par && on_tree[par] && !on_tree[child]) begin
         on_tree[child] = 1'b1;
         members.push_back(child);
         newest = child;
      end
      issue_transaction(OP_ADD, par, child);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      logic [VERTEX_W-1:0] a;
      logic [VERTEX_W-1:0] b;
      int unsigned         pick;

      on_tree[0] = 1'b1;
      members.push_back('0);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed
      issue_transaction(OP_QUERY, 10'd0, 10'd0);
      grow_tree(10'd0, 10'd1);
      grow_tree(10'd1, 10'd1);
      grow_tree(10'd1, 10'd0);
      grow_tree(10'd5, 10'd7);
      grow_tree(10'd0, 10'd1);
      grow_tree(10'd1, 10'd2);
      grow_tree(10'd2, 10'd3);
      grow_tree(10'd1, 10'd4);
      grow_tree(10'd0, 10'd1023);
      grow_tree(10'd1023, 10'd1023);
      grow_tree(10'd3, 10'd1023);
      issue_transaction(OP_QUERY, 10'd3, 10'd4);
      issue_transaction(OP_QUERY, 10'd4, 10'd3);
      issue_transaction(OP_QUERY, 10'd3, 10'd1023);
      issue_transaction(OP_QUERY, 10'd2, 10'd2);
      issue_transaction(OP_QUERY, 10'd1023, 10'd1023);
      issue_transaction(OP_QUERY, 10'd500, 10'd600);
      issue_transaction(OP_QUERY, 10'd3, 10'd700);
      issue_transaction(OP_QUERY, 10'd700, 10'd700);
      issue_transaction(OP_QUERY, 10'd0, 10'd3);
      issue_transaction(OP_QUERY, 10'd1, 10'd3);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 76; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 76; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         if (phase == 0)
            hold_off_requests++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 45 && next_child <= NUM_VERTICES - 2) begin
               // well-formed add: deep chains and fan-out
               b = next_child;
               a = ($urandom_range(1) == 0) ? newest : members[$urandom_range(members.size() - 1)];
               if (a >= b) a = '0;
               next_child += $urandom_range(4, 1);
               grow_tree(a, b);
            end else if (pick < 88) begin
               a = members[$urandom_range(members.size() - 1)];
               b = members[$urandom_range(members.size() - 1)];
               pick = $urandom_range(99);
               if (pick < 10)
                  b = a;
               else if (pick < 25)
                  b = $urandom_range(NUM_VERTICES - 1);
               issue_transaction(OP_QUERY, a, b);
            end else begin
               a = $urandom_range(NUM_VERTICES - 1);
               b = $urandom_range(NUM_VERTICES - 1);
               if ($urandom_range(1) == 0)
                  grow_tree(a, b);
               else
                  issue_transaction(OP_QUERY, a, b);
            end
         end
         drain();
      end

      repeat (3 * LEVELS + 10) @(posedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
